// ===== hw/rtl/ftmi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftmi_pkg
// Shared types and constants of the flat index unravel block.
// ----------------------------------------------------------------------------
package ftmi_pkg;

	localparam int MAX_DIMS_DEF    = 4;
	localparam int INDEX_WIDTH_DEF = 32;

	localparam int NUM_COORD = 4;
	localparam int COORD_W   = 32;
	localparam int RANK_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_W     = COORD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_BASE = 3'd1;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [DIV_W-1:0] divisor;
		logic             zero;
	} dim_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ftmi_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftmi_cfg
// Shape registers and per-dimension divisor control.
// ----------------------------------------------------------------------------
module ftmi_cfg #(
	parameter int MAX_DIMS = ftmi_pkg::MAX_DIMS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ftmi_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [ftmi_pkg::COORD_W-1:0]      cfg_wdata,
	output ftmi_pkg::dim_ctl_t [MAX_DIMS-1:0]      dim_ctl
);

	logic [ftmi_pkg::RANK_W-1:0]              rank_q;
	logic [MAX_DIMS-1:0][ftmi_pkg::COORD_W-1:0] size_q;
	logic [ftmi_pkg::RANK_W-1:0]              used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= ftmi_pkg::RANK_W'(1);
			for (int d = 0; d < MAX_DIMS; d++) begin
				size_q[d] <= ftmi_pkg::COORD_W'(1);
			end
		end else if (cfg_we) begin
			if (cfg_addr == ftmi_pkg::REG_RANK) begin
				rank_q <= cfg_wdata[ftmi_pkg::RANK_W-1:0];
			end
			for (int d = 0; d < MAX_DIMS; d++) begin
				if (cfg_addr == ftmi_pkg::REG_DIM_BASE + ftmi_pkg::CFG_IDX_W'(d)) begin
					size_q[d] <= cfg_wdata;
				end
			end
		end
	end

	always_comb begin
		used = (rank_q > ftmi_pkg::RANK_W'(MAX_DIMS)) ? ftmi_pkg::RANK_W'(MAX_DIMS) : rank_q;
		for (int d = 0; d < MAX_DIMS; d++) begin
			if (ftmi_pkg::RANK_W'(d) >= used) begin
				dim_ctl[d].divisor = ftmi_pkg::DIV_W'(1);
				dim_ctl[d].zero    = 1'b0;
			end else if (size_q[d] == '0) begin
				dim_ctl[d].divisor = {1'b1, {ftmi_pkg::COORD_W{1'b0}}};
				dim_ctl[d].zero    = 1'b1;
			end else begin
				dim_ctl[d].divisor = {1'b0, size_q[d]};
				dim_ctl[d].zero    = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ftmi_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftmi_div_stage
// One restoring division step: one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ftmi_div_stage #(
	parameter int INDEX_W = ftmi_pkg::INDEX_WIDTH_DEF,
	parameter int N_COORD = ftmi_pkg::MAX_DIMS_DEF,
	parameter int SLOT    = 0,
	parameter bit LAST    = 1'b0
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    en,
	input  wire ftmi_pkg::dim_ctl_t                      ctl,
	input  wire logic                                    up_vld,
	input  wire logic [INDEX_W-1:0]                      up_quo,
	input  wire logic [ftmi_pkg::COORD_W-1:0]            up_rem,
	input  wire logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0] up_crd,
	output logic                                         vld_s1,
	output logic [INDEX_W-1:0]                           quo_s1,
	output logic [ftmi_pkg::COORD_W-1:0]                 rem_s1,
	output logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0]    crd_s1
);

	logic [ftmi_pkg::COORD_W:0]                r_sh;
	logic [ftmi_pkg::COORD_W+1:0]              diff;
	logic                                      ge;
	logic [ftmi_pkg::COORD_W-1:0]              rem_div;
	logic [ftmi_pkg::COORD_W-1:0]              rem_nxt;
	logic [INDEX_W-1:0]                        quo_nxt;
	logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0] crd_nxt;

	always_comb begin
		r_sh    = {up_rem, up_quo[INDEX_W-1]};
		diff    = {1'b0, r_sh} - {1'b0, ctl.divisor};
		ge      = !diff[ftmi_pkg::COORD_W+1];
		rem_div = ge ? diff[ftmi_pkg::COORD_W-1:0] : r_sh[ftmi_pkg::COORD_W-1:0];
		quo_nxt = {up_quo[INDEX_W-2:0], ge};
		rem_nxt = rem_div;
		crd_nxt = up_crd;
		if (LAST) begin
			crd_nxt[SLOT] = rem_div;
			rem_nxt       = '0;
			if (ctl.zero) begin
				quo_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1 <= quo_nxt;
			rem_s1 <= rem_nxt;
			crd_s1 <= crd_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ftmi_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftmi_out_buf
// Output register with one skid entry; stalls the pipeline only when full.
// ----------------------------------------------------------------------------
module ftmi_out_buf #(
	parameter int N_COORD = ftmi_pkg::MAX_DIMS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      tail_vld,
	input  wire logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0] tail_crd,
	input  wire logic                                      out_ready,
	output logic                                           pipe_en,
	output logic                                           out_valid,
	output logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0]      out_crd
);

	logic                                      out_vld_q;
	logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0] out_crd_q;
	logic                                      skid_vld_q;
	logic [N_COORD-1:0][ftmi_pkg::COORD_W-1:0] skid_crd_q;
	logic                                      take;

	assign take      = out_vld_q && out_ready;
	assign pipe_en   = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_crd   = out_crd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (tail_vld) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_crd_q <= skid_crd_q;
			end
		end else if (tail_vld) begin
			if (!out_vld_q || take) begin
				out_crd_q <= tail_crd;
			end else begin
				skid_crd_q <= tail_crd;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/flat_to_multi_index_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// flat_to_multi_index_core
// Mixed-radix unravel of a flat row-major index into per-dimension coordinates.
// ----------------------------------------------------------------------------
// Takes one flat index per cycle while the output skid entry is empty and
// returns its coordinates against the configured shape, innermost dimension
// first, outermost coordinate wrapped modulo its size. Each dimension is a
// chain of INDEX_WIDTH restoring divider stages, one quotient bit per stage,
// followed by one output register. A two-entry output buffer absorbs a
// stalled result, so a request is still taken while a result waits. Write
// the shape registers only while no request is in flight.
module flat_to_multi_index_core #(
	parameter int MAX_DIMS    = ftmi_pkg::MAX_DIMS_DEF,
	parameter int INDEX_WIDTH = ftmi_pkg::INDEX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ftmi_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [ftmi_pkg::COORD_W-1:0]     cfg_wdata,
	input  wire logic                             idx_valid,
	output logic                                  idx_ready,
	input  wire logic [ftmi_pkg::COORD_W-1:0]     flat_index,
	output logic                                  crd_valid,
	input  wire logic                             crd_ready,
	output logic [ftmi_pkg::COORD_W-1:0]          coord_0,
	output logic [ftmi_pkg::COORD_W-1:0]          coord_1,
	output logic [ftmi_pkg::COORD_W-1:0]          coord_2,
	output logic [ftmi_pkg::COORD_W-1:0]          coord_3
);

	localparam int NS = MAX_DIMS * INDEX_WIDTH;

	ftmi_pkg::dim_ctl_t [MAX_DIMS-1:0]          dim_ctl;
	logic                                       pipe_en;
	logic [NS:0]                                pipe_vld;
	logic [NS:0][INDEX_WIDTH-1:0]               pipe_quo;
	logic [NS:0][ftmi_pkg::COORD_W-1:0]         pipe_rem;
	logic [NS:0][MAX_DIMS-1:0][ftmi_pkg::COORD_W-1:0] pipe_crd;
	logic [INDEX_WIDTH+ftmi_pkg::COORD_W-1:0]   idx_ext;
	logic [MAX_DIMS-1:0][ftmi_pkg::COORD_W-1:0] out_crd;
	ftmi_pkg::coord_t [ftmi_pkg::NUM_COORD-1:0] crd_all;

	ftmi_cfg #(
		.MAX_DIMS (MAX_DIMS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.dim_ctl   (dim_ctl)
	);

	assign idx_ready   = pipe_en;
	assign idx_ext     = {{INDEX_WIDTH{1'b0}}, flat_index};
	assign pipe_vld[0] = idx_valid;
	assign pipe_quo[0] = idx_ext[INDEX_WIDTH-1:0];
	assign pipe_rem[0] = '0;
	assign pipe_crd[0] = '0;

	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
		for (genvar k = 0; k < INDEX_WIDTH; k++) begin : g_bit
			localparam int S = g * INDEX_WIDTH + k;
			ftmi_div_stage #(
				.INDEX_W (INDEX_WIDTH),
				.N_COORD (MAX_DIMS),
				.SLOT    (MAX_DIMS - 1 - g),
				.LAST    (k == INDEX_WIDTH - 1)
			) u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (pipe_en),
				.ctl    (dim_ctl[MAX_DIMS-1-g]),
				.up_vld (pipe_vld[S]),
				.up_quo (pipe_quo[S]),
				.up_rem (pipe_rem[S]),
				.up_crd (pipe_crd[S]),
				.vld_s1 (pipe_vld[S+1]),
				.quo_s1 (pipe_quo[S+1]),
				.rem_s1 (pipe_rem[S+1]),
				.crd_s1 (pipe_crd[S+1])
			);
		end
	end

	ftmi_out_buf #(
		.N_COORD (MAX_DIMS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tail_vld  (pipe_vld[NS]),
		.tail_crd  (pipe_crd[NS]),
		.out_ready (crd_ready),
		.pipe_en   (pipe_en),
		.out_valid (crd_valid),
		.out_crd   (out_crd)
	);

	always_comb begin
		crd_all = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			crd_all[d] = out_crd[d];
		end
	end

	assign coord_0 = crd_all[0];
	assign coord_1 = crd_all[1];
	assign coord_2 = crd_all[2];
	assign coord_3 = crd_all[3];

`ifndef SYNTHESIS
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!idx_ready |-> crd_valid)
		else $error("pipeline stalled with no result presented");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_ready && crd_valid && !crd_ready && pipe_vld[NS]) |=> !idx_ready)
		else $error("held result and arriving result did not stall the pipeline");

	a_skid_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!idx_ready && crd_ready) |=> (crd_valid && idx_ready))
		else $error("buffered result not moved to the output");

	a_tail_rem_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_vld[NS] |-> (pipe_rem[NS] == '0 && pipe_quo[NS] <= pipe_quo[NS]))
		else $error("remainder left over at the end of the pipeline");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_flat_to_multi_index_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_flat_to_multi_index_core
// Self-checking bench for the flat index unravel block.
// ----------------------------------------------------------------------------
// A clocked driver feeds flat index requests from a backlog in bursts with
// random gaps, while the coordinate side stalls on a rotating ready pattern.
// Each accepted request is unraveled against a local copy of the shape
// registers and the coordinate sets are compared in order as they come out.
// A directed set of shapes covers the reset shape, rank zero, saturated rank,
// zero-size and full-width dimensions, wrapping indices and ignored register
// writes. Random shapes with mostly in-range indices follow. The shape is
// only rewritten once every pending result has come back.
// ----------------------------------------------------------------------------
module tb_flat_to_multi_index_core;

	localparam int MAX_DIMS    = ftmi_pkg::MAX_DIMS_DEF;
	localparam int INDEX_WIDTH = ftmi_pkg::INDEX_WIDTH_DEF;
	localparam int DRAIN       = MAX_DIMS * INDEX_WIDTH + 32;
	localparam int LIMIT       = 400000;
	localparam int NUM_ITEMS   = 1600;
	localparam int SLOT_W      = $clog2(ftmi_pkg::NUM_COORD);

	typedef ftmi_pkg::coord_t [ftmi_pkg::NUM_COORD-1:0] coord_vec_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cfg_we     = 1'b0;
	logic [ftmi_pkg::CFG_IDX_W-1:0] cfg_addr   = '0;
	ftmi_pkg::coord_t               cfg_wdata  = '0;
	logic                           idx_valid  = 1'b0;
	logic                           idx_ready;
	ftmi_pkg::coord_t               flat_index = '0;
	logic                           crd_valid;
	logic                           crd_ready  = 1'b0;
	ftmi_pkg::coord_t               coord_0;
	ftmi_pkg::coord_t               coord_1;
	ftmi_pkg::coord_t               coord_2;
	ftmi_pkg::coord_t               coord_3;

	ftmi_pkg::coord_t            index_backlog[$];
	coord_vec_t                  want_coords[$];
	logic [ftmi_pkg::RANK_W-1:0] shape_rank = ftmi_pkg::RANK_W'(1);
	ftmi_pkg::coord_t            shape_size [ftmi_pkg::NUM_COORD] = '{default: 32'd1};

	int mismatches      = 0;
	int requests_taken  = 0;
	int results_checked = 0;
	int shapes_run      = 0;
	int queued          = 0;
	int cycle_count     = 0;
	int burst_left      = 8;
	int gap_left        = 0;
	int stall_age       = 0;
	logic [15:0] ready_pattern = 16'hFFFF;

	flat_to_multi_index_core #(
		.MAX_DIMS    (MAX_DIMS),
		.INDEX_WIDTH (INDEX_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.idx_valid  (idx_valid),
		.idx_ready  (idx_ready),
		.flat_index (flat_index),
		.crd_valid  (crd_valid),
		.crd_ready  (crd_ready),
		.coord_0    (coord_0),
		.coord_1    (coord_1),
		.coord_2    (coord_2),
		.coord_3    (coord_3)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int dims_in_use();
		return (int'(shape_rank) > MAX_DIMS) ? MAX_DIMS : int'(shape_rank);
	endfunction

	function automatic coord_vec_t unravel_index(ftmi_pkg::coord_t flat);
		coord_vec_t       crd;
		ftmi_pkg::coord_t rem;
		crd = '0;
		rem = flat;
		for (int d = dims_in_use() - 1; d >= 0; d--) begin
			if (shape_size[d] == '0) begin
				crd[d] = rem;
				rem = '0;
			end else begin
				crd[d] = rem % shape_size[d];
				rem = rem / shape_size[d];
			end
		end
		return crd;
	endfunction

	function automatic ftmi_pkg::coord_t pick_index();
		longint unsigned total;
		total = 1;
		for (int d = 0; d < dims_in_use(); d++) begin
			if (total <= 64'h1_0000_0000)
				total = total * ((shape_size[d] == '0) ? 64'h1_0000_0000 : 64'(shape_size[d]));
		end
		case ($urandom_range(0, 19))
			0, 1, 2: return $urandom;
			3: return '0;
			4: return '1;
			5: return ftmi_pkg::coord_t'(1) << $urandom_range(0, 31);
			6, 7: return (total <= 64'h1_0000_0000)
				? ftmi_pkg::coord_t'(total - 1 + $urandom_range(0, 2)) : $urandom;
			default: return (total < 64'h1_0000_0000)
				? $urandom_range(0, int'(total - 1)) : $urandom;
		endcase
	endfunction

	function automatic ftmi_pkg::coord_t pick_size();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 32'd1;
			2, 3, 4, 5: return $urandom_range(2, 16);
			6, 7: return $urandom_range(17, 1000);
			8: return $urandom;
			9: return '1;
			default: return ftmi_pkg::coord_t'(1) << $urandom_range(1, 31);
		endcase
	endfunction

	function automatic ftmi_pkg::coord_t pick_rank_word();
		ftmi_pkg::coord_t w;
		case ($urandom_range(0, 9))
			0: w = 32'd0;
			1: w = $urandom_range(MAX_DIMS + 1, 7);
			default: w = $urandom_range(1, MAX_DIMS);
		endcase
		return ($urandom & ~32'h7) | w;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (index_backlog.size() != 0 || idx_valid || want_coords.size() != 0);
	endtask

	task automatic write_reg(input logic [ftmi_pkg::CFG_IDX_W-1:0] addr,
			input ftmi_pkg::coord_t data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		if (addr == ftmi_pkg::REG_RANK)
			shape_rank = data[ftmi_pkg::RANK_W-1:0];
		else if (int'(addr) < int'(ftmi_pkg::REG_DIM_BASE) + ftmi_pkg::NUM_COORD)
			shape_size[SLOT_W'(addr - ftmi_pkg::REG_DIM_BASE)] = data;
	endtask

	task automatic write_shape(input ftmi_pkg::coord_t rank_word, input ftmi_pkg::coord_t s0,
			input ftmi_pkg::coord_t s1, input ftmi_pkg::coord_t s2,
			input ftmi_pkg::coord_t s3);
		write_reg(ftmi_pkg::REG_RANK, rank_word);
		write_reg(ftmi_pkg::REG_DIM_BASE, s0);
		write_reg(ftmi_pkg::REG_DIM_BASE + 3'd1, s1);
		write_reg(ftmi_pkg::REG_DIM_BASE + 3'd2, s2);
		write_reg(ftmi_pkg::REG_DIM_BASE + 3'd3, s3);
	endtask

	task automatic close_shape();
		@(posedge clk);
		cfg_we <= 1'b0;
		shapes_run++;
	endtask

	task automatic queue_index(input ftmi_pkg::coord_t value);
		index_backlog.push_back(value);
		queued++;
	endtask

	initial begin
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset shape
		shapes_run++;
		queue_index('0);
		queue_index('1);
		queue_index(32'd12345);

		wait_idle();
		write_shape(32'd4, 32'd3, 32'd4, 32'd5, 32'd6);
		close_shape();
		queue_index('0);
		queue_index(32'd359);
		queue_index(32'd360);
		queue_index(32'd123);
		queue_index('1);

		wait_idle();
		write_shape(32'hFFFF_FFF8, 32'd7, 32'd7, 32'd7, 32'd7);
		close_shape();
		queue_index(32'd5);
		queue_index('1);

		wait_idle();
		write_shape('1, '0, '0, '0, '0);
		close_shape();
		queue_index(32'hDEAD_BEEF);
		queue_index('1);

		wait_idle();
		write_shape(32'd2, '1, '1, 32'd9, 32'd9);
		close_shape();
		queue_index('1);
		queue_index(32'hFFFF_FFFE);
		queue_index(32'h8000_0000);

		wait_idle();
		write_shape(32'd3, 32'd7, 32'd9, '0, 32'd2);
		write_reg(3'd5, '1);
		write_reg(3'd6, 32'h5A5A_A5A5);
		write_reg(3'd7, '0);
		close_shape();
		queue_index(32'd100);
		queue_index('1);
		queue_index(32'd630);

		while (queued < NUM_ITEMS) begin
			wait_idle();
			write_shape(pick_rank_word(), pick_size(), pick_size(), pick_size(), pick_size());
			if ($urandom_range(0, 3) == 0)
				write_reg(ftmi_pkg::CFG_IDX_W'($urandom_range(5, 7)), $urandom);
			close_shape();
			n = $urandom_range(20, 120);
			repeat (n) queue_index(pick_index());
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		$display("tb: %0d flat index requests over %0d shapes, %0d coordinate sets compared",
			requests_taken, shapes_run, results_checked);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin : idx_driver
		if (arst_n) begin
			if (!idx_valid || idx_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					idx_valid <= 1'b0;
				end else if (index_backlog.size() > 0) begin
					idx_valid  <= 1'b1;
					flat_index <= index_backlog.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					idx_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : crd_stall
		if (arst_n) begin
			stall_age++;
			if (stall_age >= 64) begin
				stall_age = 0;
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hFFFF;
					1: ready_pattern = 16'($urandom) | 16'h0001;
					2: ready_pattern = 16'h0001;
					default: ready_pattern = 16'h0F0F;
				endcase
			end
			crd_ready     <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
	end

	always @(posedge clk) begin : crd_monitor
		coord_vec_t got;
		coord_vec_t want;
		if (arst_n) begin
			if (crd_valid && crd_ready) begin
				got = {coord_3, coord_2, coord_1, coord_0};
				if (want_coords.size() == 0) begin
					$error("coordinate set %h with no pending request", got);
					mismatches++;
				end else begin
					want = want_coords.pop_front();
					for (int d = 0; d < ftmi_pkg::NUM_COORD; d++) begin
						if (got[d] !== want[d]) begin
							$error("coord_%0d: expected %h, actual %h", d, want[d], got[d]);
							mismatches++;
						end
					end
					results_checked++;
				end
			end
			if (idx_valid && idx_ready) begin
				want_coords.push_back(unravel_index(flat_index));
				requests_taken++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/ftmi_pkg.sv
hw/rtl/ftmi_cfg.sv
hw/rtl/ftmi_div_stage.sv
hw/rtl/ftmi_out_buf.sv
hw/rtl/flat_to_multi_index_core.sv
verif/tb_flat_to_multi_index_core.sv
